/* hdl/qptj_pkg.sv */
// qptj_pkg: shared types, widths, codes and tables for the quaternion point transform core
// depends on nothing; imported by every module of the core
package qptj_pkg;

	localparam int COORD_WIDTH    = 24;
	localparam int QUAT_FRAC_BITS = 14;

	localparam int QUAT_W   = 16;
	localparam int QSEL_W   = QUAT_W + 1;
	localparam int QPROD_W  = 2 * QUAT_W;
	localparam int ROW_W    = QPROD_W + 3;
	localparam int DV_W     = COORD_WIDTH + 1;
	localparam int PROD_W   = DV_W + ROW_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int OUT_W    = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int COL_SHIFT = 2 * QUAT_FRAC_BITS - 8;

	localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [QUAT_W-1:0]      quat_t;
	typedef logic signed [QSEL_W-1:0]      qsel_t;
	typedef logic signed [QPROD_W-1:0]     qprod_t;
	typedef logic signed [ROW_W-1:0]       row_t;
	typedef logic signed [DV_W-1:0]        dv_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [ACC_W-1:0]       acc_t;
	typedef logic signed [OUT_W-1:0]       out_t;

	typedef enum logic [1:0] {
		OP_XFORM = 2'd0,
		OP_DS    = 2'd1,
		OP_DT    = 2'd2,
		OP_DQUAT = 2'd3
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRANS_X = 3'd0,
		CFG_TRANS_Y = 3'd1,
		CFG_TRANS_Z = 3'd2,
		CFG_QUAT_A  = 3'd3,
		CFG_QUAT_B  = 3'd4,
		CFG_QUAT_C  = 3'd5,
		CFG_QUAT_D  = 3'd6
	} cfg_reg_e;

	localparam logic [1:0] AXIS_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] deriv_index;
		coord_t     point_x;
		coord_t     point_y;
		coord_t     point_z;
	} req_t;

	typedef struct packed {
		out_t out_x;
		out_t out_y;
		out_t out_z;
		logic saturated;
	} rsp_t;

	typedef struct packed {
		coord_t trans_x;
		coord_t trans_y;
		coord_t trans_z;
		quat_t  quat_a;
		quat_t  quat_b;
		quat_t  quat_c;
		quat_t  quat_d;
	} pose_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_out;
	} pipe_en_t;

	typedef struct packed {
		op_e                  op;
		logic [1:0]           k;
		dv_t  [2:0]           dv;
		row_t [2:0][2:0]      rows;
		qsel_t [2:0][2:0]     qsel;
	} front_out_t;

	typedef struct packed {
		op_e         op;
		logic [1:0]  k;
		dv_t  [2:0]  dv;
		row_t [2:0]  row;
		qsel_t [2:0] qsel;
	} lane_in_t;

	typedef struct packed {
		out_t val;
		logic clip;
	} lane_res_t;

	// half-derivative selection: [row][component][k], 1..4 pick a..d, negative negates
	localparam logic signed [3:0] HALF_DERIV [3][3][4] = '{
		'{ '{ 1,  2, -3, -4}, '{ 4,  3,  2,  1}, '{-3,  4, -1,  2} },
		'{ '{-4,  3,  2, -1}, '{ 1, -2,  3, -4}, '{ 2,  1,  4,  3} },
		'{ '{ 3,  4,  1,  2}, '{-2, -1,  4,  3}, '{ 1, -2, -3,  4} }
	};

	// clip a wide signed value to the 32-bit signed range
	function automatic lane_res_t sat32(input acc_t v);
		lane_res_t r;
		logic [ACC_W-OUT_W:0] hi;
		hi = v[ACC_W-1:OUT_W-1];
		if ((&hi) || !(|hi)) begin
			r.val  = v[OUT_W-1:0];
			r.clip = 1'b0;
		end else begin
			r.val  = v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
			r.clip = 1'b1;
		end
		return r;
	endfunction

endpackage

/* hdl/quaternion_point_transform_jacobian_core.sv */
// quaternion_point_transform_jacobian_core: point transform and Jacobians under a fixed pose
// path: a request passes through stages s1, s2, s3 and s4 into the output register
// throughput: one transaction per cycle while rsp_stall is low, set by the five-stage pipeline with per-stage valids
// a full stage waits only for the stage after it, so bubbles close up under rsp_stall
// reset: all valid flags clear; pose resets to zero translation and the unit quaternion
// depends on qptj_pkg, qptj_front, qptj_lane, qptj_merge
module quaternion_point_transform_jacobian_core import qptj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	pose_t           pose_q;
	logic            v_s1, v_s2, v_s3, v_s4, rsp_valid_q;
	pipe_en_t        pen;
	front_out_t      fout;
	lane_in_t [2:0]  lin;
	lane_res_t [2:0] lres;

	// configuration writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q.trans_x <= '0;
			pose_q.trans_y <= '0;
			pose_q.trans_z <= '0;
			pose_q.quat_a  <= QUAT_ONE;
			pose_q.quat_b  <= '0;
			pose_q.quat_c  <= '0;
			pose_q.quat_d  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_e'(cfg_index))
				CFG_TRANS_X: pose_q.trans_x <= cfg_data[COORD_WIDTH-1:0];
				CFG_TRANS_Y: pose_q.trans_y <= cfg_data[COORD_WIDTH-1:0];
				CFG_TRANS_Z: pose_q.trans_z <= cfg_data[COORD_WIDTH-1:0];
				CFG_QUAT_A:  pose_q.quat_a  <= cfg_data[QUAT_W-1:0];
				CFG_QUAT_B:  pose_q.quat_b  <= cfg_data[QUAT_W-1:0];
				CFG_QUAT_C:  pose_q.quat_c  <= cfg_data[QUAT_W-1:0];
				CFG_QUAT_D:  pose_q.quat_d  <= cfg_data[QUAT_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control: a stage loads when it is empty or its successor loads
	assign pen.en_out = !rsp_valid_q || !rsp_stall;
	assign pen.en_s4  = !v_s4 || pen.en_out;
	assign pen.en_s3  = !v_s3 || pen.en_s4;
	assign pen.en_s2  = !v_s2 || pen.en_s3;
	assign pen.en_s1  = !v_s1 || pen.en_s2;
	assign req_stall  = !pen.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pen.en_s1) begin
				v_s1 <= req_valid;
			end
			if (pen.en_s2) begin
				v_s2 <= v_s1;
			end
			if (pen.en_s3) begin
				v_s3 <= v_s2;
			end
			if (pen.en_s4) begin
				v_s4 <= v_s3;
			end
			if (pen.en_out) begin
				rsp_valid_q <= v_s4;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	// offset, quaternion products and rotation rows (s1, s2)
	qptj_front u_front (
		.clk  (clk),
		.pen  (pen),
		.req  (req),
		.pose (pose_q),
		.fout (fout)
	);

	// one lane per output component, each fed its matrix row (s3, s4)
	for (genvar i = 0; i < 3; i++) begin : g_lane
		assign lin[i].op   = fout.op;
		assign lin[i].k    = fout.k;
		assign lin[i].dv   = fout.dv;
		assign lin[i].row  = fout.rows[i];
		assign lin[i].qsel = fout.qsel[i];

		qptj_lane u_lane (
			.clk (clk),
			.pen (pen),
			.lin (lin[i]),
			.res (lres[i])
		);
	end

	// combine lane results and clip flags into the response register
	qptj_merge u_merge (
		.clk  (clk),
		.pen  (pen),
		.lres (lres),
		.rsp  (rsp)
	);

`ifndef SYNTHESIS
	// a stalled request means the first stage holds a transaction
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> v_s1) else $error("request stalled with empty first stage");

	// an accepted request occupies the first stage on the next cycle
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> v_s1) else $error("accepted request lost");

	// with no response pending the pipeline never pushes back
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall) else $error("stall with free output register");

	// a finished lane result moves into the response register when it is free
	a_s4_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && pen.en_out) |=> rsp_valid) else $error("result dropped at output");
`endif

endmodule

/* hdl/qptj_front.sv */
// qptj_front: point offset, quaternion products, rotation rows and half-derivative selects
// depends on qptj_pkg; stages s1 and s2 of the core
module qptj_front import qptj_pkg::*; (
	input  logic       clk,
	input  pipe_en_t   pen,
	input  req_t       req,
	input  pose_t      pose,
	output front_out_t fout
);

	op_e        op_s1;
	logic [1:0] k_s1;
	dv_t [2:0]  dv_s1;
	qprod_t     aa_s1, bb_s1, cc_s1, dd_s1, ab_s1, ac_s1, ad_s1, bc_s1, bd_s1, cd_s1;
	qsel_t [2:0][2:0] qsel_s1;
	qsel_t [2:0][2:0] qsel_c;
	qsel_t [4:0] qv;
	front_out_t fout_s2;

	assign qv[0] = '0;
	assign qv[1] = qsel_t'(pose.quat_a);
	assign qv[2] = qsel_t'(pose.quat_b);
	assign qv[3] = qsel_t'(pose.quat_c);
	assign qv[4] = qsel_t'(pose.quat_d);

	// table lookup of the quaternion part that multiplies each offset axis
	always_comb begin
		logic signed [3:0] sel;
		logic [2:0]        idx;
		qsel_t             v;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sel = HALF_DERIV[i][j][req.deriv_index];
				idx = sel[3] ? 3'(-sel) : sel[2:0];
				case (idx)
					3'd1:    v = qv[1];
					3'd2:    v = qv[2];
					3'd3:    v = qv[3];
					3'd4:    v = qv[4];
					default: v = qv[0];
				endcase
				qsel_c[i][j] = sel[3] ? -v : v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pen.en_s1) begin
			op_s1    <= op_e'(req.req_type);
			k_s1     <= req.deriv_index;
			dv_s1[0] <= dv_t'(req.point_x) - dv_t'(pose.trans_x);
			dv_s1[1] <= dv_t'(req.point_y) - dv_t'(pose.trans_y);
			dv_s1[2] <= dv_t'(req.point_z) - dv_t'(pose.trans_z);
			aa_s1    <= pose.quat_a * pose.quat_a;
			bb_s1    <= pose.quat_b * pose.quat_b;
			cc_s1    <= pose.quat_c * pose.quat_c;
			dd_s1    <= pose.quat_d * pose.quat_d;
			ab_s1    <= pose.quat_a * pose.quat_b;
			ac_s1    <= pose.quat_a * pose.quat_c;
			ad_s1    <= pose.quat_a * pose.quat_d;
			bc_s1    <= pose.quat_b * pose.quat_c;
			bd_s1    <= pose.quat_b * pose.quat_d;
			cd_s1    <= pose.quat_c * pose.quat_d;
			qsel_s1  <= qsel_c;
		end
	end

	always_ff @(posedge clk) begin
		if (pen.en_s2) begin
			fout_s2.op   <= op_s1;
			fout_s2.k    <= k_s1;
			fout_s2.dv   <= dv_s1;
			fout_s2.qsel <= qsel_s1;
			fout_s2.rows[0][0] <= row_t'(aa_s1) + row_t'(bb_s1) - row_t'(cc_s1) - row_t'(dd_s1);
			fout_s2.rows[0][1] <= (row_t'(bc_s1) + row_t'(ad_s1)) <<< 1;
			fout_s2.rows[0][2] <= (row_t'(bd_s1) - row_t'(ac_s1)) <<< 1;
			fout_s2.rows[1][0] <= (row_t'(bc_s1) - row_t'(ad_s1)) <<< 1;
			fout_s2.rows[1][1] <= row_t'(aa_s1) - row_t'(bb_s1) + row_t'(cc_s1) - row_t'(dd_s1);
			fout_s2.rows[1][2] <= (row_t'(cd_s1) + row_t'(ab_s1)) <<< 1;
			fout_s2.rows[2][0] <= (row_t'(bd_s1) + row_t'(ac_s1)) <<< 1;
			fout_s2.rows[2][1] <= (row_t'(cd_s1) - row_t'(ab_s1)) <<< 1;
			fout_s2.rows[2][2] <= row_t'(aa_s1) - row_t'(bb_s1) - row_t'(cc_s1) + row_t'(dd_s1);
		end
	end

	assign fout = fout_s2;

endmodule

/* hdl/qptj_lane.sv */
// qptj_lane: one output component; three multipliers, sum, scaling and clipping
// depends on qptj_pkg; stages s3 and s4 of the core
module qptj_lane import qptj_pkg::*; (
	input  logic      clk,
	input  pipe_en_t  pen,
	input  lane_in_t  lin,
	output lane_res_t res
);

	row_t [2:0]  mul_op;
	prod_t [2:0] prod_s3;
	acc_t        col_s3;
	op_e         op_s3;
	acc_t        col_c;
	row_t        col_row;
	acc_t        sum_c;
	acc_t        scaled_c;
	lane_res_t   res_s4;

	// derivative wrt quaternion uses the selected parts, everything else the matrix row
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mul_op[j] = (lin.op == OP_DQUAT) ? row_t'(lin.qsel[j]) : lin.row[j];
		end
	end

	// matrix column entry, floor-shifted to 8 fraction bits; negated for OP_DT, zero for AXIS_NONE
	always_comb begin
		case (lin.k)
			2'd0:    col_row = lin.row[0];
			2'd1:    col_row = lin.row[1];
			2'd2:    col_row = lin.row[2];
			default: col_row = '0;
		endcase
		col_c = acc_t'(col_row) >>> COL_SHIFT;
		if (lin.k == AXIS_NONE) begin
			col_c = '0;
		end else if (lin.op == OP_DT) begin
			col_c = -col_c;
		end
	end

	always_ff @(posedge clk) begin
		if (pen.en_s3) begin
			for (int j = 0; j < 3; j++) begin
				prod_s3[j] <= prod_t'(lin.dv[j]) * prod_t'(mul_op[j]);
			end
			col_s3 <= col_c;
			op_s3  <= lin.op;
		end
	end

	always_comb begin
		sum_c = acc_t'(prod_s3[0]) + acc_t'(prod_s3[1]) + acc_t'(prod_s3[2]);
		case (op_s3)
			OP_XFORM: scaled_c = sum_c >>> (2 * QUAT_FRAC_BITS);
			OP_DQUAT: scaled_c = sum_c >>> QUAT_FRAC_BITS;
			default:  scaled_c = col_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pen.en_s4) begin
			res_s4 <= sat32(scaled_c);
		end
	end

	assign res = res_s4;

endmodule

/* hdl/qptj_merge.sv */
// qptj_merge: joins the three lane results into one response and holds it for the consumer
// depends on qptj_pkg; output register of the core
module qptj_merge import qptj_pkg::*; (
	input  logic            clk,
	input  pipe_en_t        pen,
	input  lane_res_t [2:0] lres,
	output rsp_t            rsp
);

	rsp_t rsp_q;

	always_ff @(posedge clk) begin
		if (pen.en_out) begin
			rsp_q.out_x     <= lres[0].val;
			rsp_q.out_y     <= lres[1].val;
			rsp_q.out_z     <= lres[2].val;
			rsp_q.saturated <= lres[0].clip | lres[1].clip | lres[2].clip;
		end
	end

	assign rsp = rsp_q;

endmodule
